>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the surface normal unit.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a condition never holds at a rising clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_CLK(label, !(expr), msg)

`endif

>>> rtl/core/gsn_pkg.sv
// Shared types, constants and helper functions of the surface normal unit.
// No dependencies; gsn_ctrl, gsn_datapath, the top level and the bench import it.
`timescale 1ns / 1ps

package gsn_pkg;

  localparam int MAX_COLS_DEF   = 1024;
  localparam int COORD_BITS_DEF = 16;
  localparam int NORM_W         = 16;   // Q1.14 output components
  localparam int FRAC_SHIFT     = 14;   // 1.0 == 2**14
  localparam int COLS_W         = 11;
  localparam int ROWS_W         = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;

  localparam logic [COLS_W-1:0]    COLS_RESET = 11'd1024;
  localparam logic [ROWS_W-1:0]    ROWS_RESET = 16'd1024;
  localparam logic [CFG_IDX_W-1:0] REG_COLS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS   = 2'd1;

  // Width of the summed cross product components; capped at 64 bits.
  function automatic int acc_width(int cb);
    return (2 * cb + 4 > 64) ? 64 : 2 * cb + 4;
  endfunction

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RD_UP,
    ST_RD_C,
    ST_RD_L,
    ST_RD_R,
    ST_RD_LAST,
    ST_X_LOAD,
    ST_X_MUL,
    ST_SQ,
    ST_SQ_WAIT,
    ST_ZCHK,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_END,
    ST_OUT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    RD_UP,
    RD_C,
    RD_L,
    RD_R
  } rd_sel_e;

  typedef enum logic [3:0] {
    OP_X_P,
    OP_X_N,
    OP_Y_P,
    OP_Y_N,
    OP_Z_P,
    OP_Z_N,
    OP_SQ_HH,
    OP_SQ_HL,
    OP_SQ_LL
  } mul_op_e;

  typedef struct packed {
    logic       accept;
    logic       rd_en;
    rd_sel_e    rd_sel;
    logic       cap_en;
    rd_sel_e    cap_sel;
    logic       mem_we;
    logic       tri_load;
    logic [1:0] tri_idx;
    logic       mul_en;
    mul_op_e    mul_op;
    logic [1:0] comp_idx;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_store;
    logic       res_load;
  } gsn_cmd_t;

  typedef struct packed {
    logic [3:0] tri_en;
    logic       r_zero;
    logic       sum_zero;
    logic       out_full;
  } gsn_status_t;

  // Six partial products of one cross product, in issue order.
  function automatic mul_op_e cross_op(logic [2:0] step);
    mul_op_e op;
    unique case (step)
      3'd0:    op = OP_X_P;
      3'd1:    op = OP_X_N;
      3'd2:    op = OP_Y_P;
      3'd3:    op = OP_Y_N;
      3'd4:    op = OP_Z_P;
      default: op = OP_Z_N;
    endcase
    return op;
  endfunction

  // Three partial products of one squared magnitude.
  function automatic mul_op_e sq_op(logic [1:0] part);
    mul_op_e op;
    unique case (part)
      2'd0:    op = OP_SQ_HH;
      2'd1:    op = OP_SQ_HL;
      default: op = OP_SQ_LL;
    endcase
    return op;
  endfunction

endpackage

>>> rtl/core/gsn_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module gsn_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/gsn_ctrl.sv
// Sequencer of the surface normal unit: steps one item through reads,
// cross products, squares, square root and divisions. Uses gsn_pkg.
`timescale 1ns / 1ps

module gsn_ctrl
  import gsn_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  gsn_status_t status_i,
  output gsn_cmd_t    cmd_o
);

  localparam int ACC_W = acc_width(COORD_BITS);
  localparam int DV_W  = ACC_W + FRAC_SHIFT;
  localparam int CNT_W = $clog2(DV_W + 1);

  localparam logic [CNT_W-1:0] LAST_CROSS = CNT_W'(5);
  localparam logic [CNT_W-1:0] LAST_PART  = CNT_W'(2);
  localparam logic [CNT_W-1:0] LAST_SQRT  = CNT_W'(ACC_W - 1);
  localparam logic [CNT_W-1:0] LAST_DIV   = CNT_W'(DV_W - 1);
  localparam logic [1:0]       LAST_TRI   = 2'd3;
  localparam logic [1:0]       LAST_COMP  = 2'd2;

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       tri_q, tri_d;
  logic [1:0]       comp_q, comp_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      tri_q   <= '0;
      comp_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      tri_q   <= tri_d;
      comp_q  <= comp_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    tri_d   = tri_q;
    comp_d  = comp_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_RD_UP;
        end
      end
      ST_RD_UP:   state_d = ST_RD_C;
      ST_RD_C:    state_d = ST_RD_L;
      ST_RD_L:    state_d = ST_RD_R;
      ST_RD_R:    state_d = ST_RD_LAST;
      ST_RD_LAST: begin
        tri_d   = '0;
        state_d = status_i.r_zero ? ST_IDLE : ST_X_LOAD;
      end
      ST_X_LOAD: begin
        cnt_d  = '0;
        comp_d = '0;
        if (status_i.tri_en[tri_q]) begin
          state_d = ST_X_MUL;
        end else if (tri_q == LAST_TRI) begin
          state_d = ST_SQ;
        end else begin
          tri_d = tri_q + 2'd1;
        end
      end
      ST_X_MUL: begin
        if (cnt_q == LAST_CROSS) begin
          cnt_d  = '0;
          comp_d = '0;
          if (tri_q == LAST_TRI) begin
            state_d = ST_SQ;
          end else begin
            tri_d   = tri_q + 2'd1;
            state_d = ST_X_LOAD;
          end
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_SQ: begin
        if (cnt_q == LAST_PART) begin
          cnt_d = '0;
          if (comp_q == LAST_COMP) begin
            state_d = ST_SQ_WAIT;
          end else begin
            comp_d = comp_q + 2'd1;
          end
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_SQ_WAIT: state_d = ST_ZCHK;
      ST_ZCHK: begin
        cnt_d   = '0;
        state_d = status_i.sum_zero ? ST_OUT : ST_SQRT;
      end
      ST_SQRT: begin
        if (cnt_q == LAST_SQRT) begin
          comp_d  = '0;
          state_d = ST_DIV_INIT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DIV_INIT: begin
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (cnt_q == LAST_DIV) begin
          state_d = ST_DIV_END;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_DIV_END: begin
        if (comp_q == LAST_COMP) begin
          state_d = ST_OUT;
        end else begin
          comp_d  = comp_q + 2'd1;
          state_d = ST_DIV_INIT;
        end
      end
      ST_OUT: begin
        if (!status_i.out_full) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.rd_sel   = RD_UP;
    cmd_o.cap_sel  = RD_UP;
    cmd_o.mul_op   = OP_X_P;
    cmd_o.tri_idx  = tri_q;
    cmd_o.comp_idx = comp_q;
    in_ready_o     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_RD_UP: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_UP;
      end
      ST_RD_C: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_C;
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = RD_UP;
      end
      ST_RD_L: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_L;
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = RD_C;
      end
      ST_RD_R: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_sel  = RD_R;
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = RD_L;
      end
      ST_RD_LAST: begin
        cmd_o.cap_en  = 1'b1;
        cmd_o.cap_sel = RD_R;
        cmd_o.mem_we  = 1'b1;
      end
      ST_X_LOAD: cmd_o.tri_load = status_i.tri_en[tri_q];
      ST_X_MUL: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = cross_op(cnt_q[2:0]);
      end
      ST_SQ: begin
        cmd_o.mul_en = 1'b1;
        cmd_o.mul_op = sq_op(cnt_q[1:0]);
      end
      ST_SQ_WAIT:  ;
      ST_ZCHK:     cmd_o.sqrt_init = 1'b1;
      ST_SQRT:     cmd_o.sqrt_step = 1'b1;
      ST_DIV_INIT: cmd_o.div_init  = 1'b1;
      ST_DIV:      cmd_o.div_step  = 1'b1;
      ST_DIV_END:  cmd_o.div_store = 1'b1;
      ST_OUT:      cmd_o.res_load  = !status_i.out_full;
      default:     ;
    endcase
  end

endmodule

>>> rtl/core/gsn_datapath.sv
// Datapath of the surface normal unit: frame counters, line store, window,
// shared multiplier, accumulators, square root, divider, output register.
// Uses gsn_pkg and gsn_ram.
`timescale 1ns / 1ps

module gsn_datapath
  import gsn_pkg::*;
#(
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  input  logic signed [COORD_BITS-1:0] vx_i,
  input  logic signed [COORD_BITS-1:0] vy_i,
  input  logic signed [COORD_BITS-1:0] vz_i,
  input  gsn_cmd_t                     cmd_i,
  output gsn_status_t                  status_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic signed [NORM_W-1:0]     nx_o,
  output logic signed [NORM_W-1:0]     ny_o,
  output logic signed [NORM_W-1:0]     nz_o,
  output logic                         zero_length_o,
  output logic                         frame_end_o
);

  localparam int CB     = COORD_BITS;
  localparam int CW     = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
  localparam int CE_W   = CW + 1;
  localparam int AW     = CW + 1;
  localparam int DEPTH  = 2 ** AW;
  localparam int DW     = 3 * CB;
  localparam int DF_W   = CB + 1;
  localparam int ACC_W  = acc_width(CB);
  localparam int LO_W   = ACC_W / 2;
  localparam int HI_W   = ACC_W - LO_W;
  localparam int MUL_W  = ((DF_W > HI_W) ? DF_W : HI_W) + 1;
  localparam int PR_W   = 2 * MUL_W;
  localparam int SQ_W   = 2 * ACC_W;
  localparam int RT_W   = ACC_W;
  localparam int RM_W   = RT_W + 1;
  localparam int RN_W   = RT_W + 3;
  localparam int DV_W   = ACC_W + FRAC_SHIFT;
  localparam int SH_HH  = 2 * LO_W;
  localparam int SH_HL  = LO_W + 1;

  // ---------------- configuration and frame position ----------------
  logic [COLS_W-1:0] cols_q;
  logic [ROWS_W-1:0] rows_q;
  logic [CW-1:0]     col_q, col_d;
  logic [ROWS_W-1:0] row_q, row_d;

  logic [31:0]       cols_ext, ce_ext;
  logic [CE_W-1:0]   ce;
  logic [ROWS_W-1:0] re;
  logic [CW-1:0]     j_eff;
  logic [ROWS_W-1:0] r_eff;
  logic [CE_W-1:0]   j_inc;

  always_comb begin
    cols_ext = 32'(cols_q);
    if (cols_ext < 32'd2) begin
      ce_ext = 32'd2;
    end else if (cols_ext > 32'(MAX_COLS)) begin
      ce_ext = 32'(MAX_COLS);
    end else begin
      ce_ext = cols_ext;
    end
    ce    = CE_W'(ce_ext);
    re    = (rows_q < 16'd2) ? 16'd2 : rows_q;
    j_eff = (CE_W'(col_q) >= ce) ? '0 : col_q;
    r_eff = (row_q > re) ? '0 : row_q;
    j_inc = CE_W'(j_eff) + CE_W'(1);
    row_d = r_eff;
    if (j_inc >= ce) begin
      col_d = '0;
      row_d = (r_eff >= re) ? '0 : r_eff + 16'd1;
    end else begin
      col_d = j_inc[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
      col_q  <= '0;
      row_q  <= '0;
    end else if (cfg_we_i) begin
      // A write to a known register restarts the frame.
      unique case (cfg_idx_i)
        REG_COLS: begin
          cols_q <= cfg_data_i[COLS_W-1:0];
          col_q  <= '0;
          row_q  <= '0;
        end
        REG_ROWS: begin
          rows_q <= cfg_data_i[ROWS_W-1:0];
          col_q  <= '0;
          row_q  <= '0;
        end
        default: ;
      endcase
    end else if (cmd_i.accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Position of the item in work
  logic [CW-1:0] j_q;
  logic          ub_q, r_zero_q, has_u_q, has_d_q, has_l_q, has_r_q, last_col_q;
  logic signed [CB-1:0] cur_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      j_q        <= j_eff;
      ub_q       <= r_eff[0];
      r_zero_q   <= (r_eff == '0);
      has_u_q    <= (r_eff >= 16'd2);
      has_d_q    <= (r_eff < re);
      has_l_q    <= (j_eff != '0);
      has_r_q    <= (j_inc < ce);
      last_col_q <= (j_inc == ce);
      cur_q[0]   <= vx_i;
      cur_q[1]   <= vy_i;
      cur_q[2]   <= vz_i;
    end
  end

  // ---------------- line store ----------------
  logic [AW-1:0] raddr, waddr;
  logic [DW-1:0] rdata, wdata;
  logic          ram_we;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_UP:   raddr = {ub_q, j_q};
      RD_C:    raddr = {~ub_q, j_q};
      RD_L:    raddr = {~ub_q, j_q - CW'(1)};
      default: raddr = {~ub_q, j_q + CW'(1)};
    endcase
    waddr  = {ub_q, j_q};
    wdata  = {cur_q[2], cur_q[1], cur_q[0]};
    ram_we = cmd_i.mem_we & has_d_q;
  end

  gsn_ram #(
    .WIDTH(DW),
    .DEPTH(DEPTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // ---------------- neighbor window ----------------
  logic signed [CB-1:0] rd_v [3];
  logic signed [CB-1:0] up_q [3];
  logic signed [CB-1:0] c_q  [3];
  logic signed [CB-1:0] l_q  [3];
  logic signed [CB-1:0] r_q  [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rd_v[k] = rdata[k*CB +: CB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_en) begin
      unique case (cmd_i.cap_sel)
        RD_UP:   up_q <= rd_v;
        RD_C:    c_q  <= rd_v;
        RD_L:    l_q  <= rd_v;
        default: r_q  <= rd_v;
      endcase
    end
  end

  // Edge vectors of one triangle P,A,B
  logic signed [CB-1:0]   p_v [3];
  logic signed [CB-1:0]   a_v [3];
  logic signed [CB-1:0]   b_v [3];
  logic signed [DF_W-1:0] da_q [3];
  logic signed [DF_W-1:0] db_q [3];

  always_comb begin
    unique case (cmd_i.tri_idx)
      2'd0: begin p_v = l_q; a_v = up_q; b_v = c_q;   end
      2'd1: begin p_v = c_q; a_v = up_q; b_v = r_q;   end
      2'd2: begin p_v = l_q; a_v = c_q;  b_v = cur_q; end
      default: begin p_v = c_q; a_v = r_q; b_v = cur_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tri_load) begin
      for (int k = 0; k < 3; k++) begin
        da_q[k] <= DF_W'(a_v[k]) - DF_W'(p_v[k]);
        db_q[k] <= DF_W'(b_v[k]) - DF_W'(p_v[k]);
      end
    end
  end

  // ---------------- shared multiplier ----------------
  logic signed [ACC_W-1:0] acc_q [3];
  logic [ACC_W-1:0]        mag_v [3];
  logic [ACC_W-1:0]        sel_mag;
  logic                    sel_neg;
  logic signed [MUL_W-1:0] ma, mb;
  logic signed [PR_W-1:0]  prod_q;
  mul_op_e                 ptag_q;
  logic                    pvalid_q;
  logic [SQ_W-1:0]         sum_q;
  logic [SQ_W-1:0]         prod_sq;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag_v[k] = acc_q[k][ACC_W-1] ? ACC_W'(-acc_q[k]) : ACC_W'(acc_q[k]);
    end
    unique case (cmd_i.comp_idx)
      2'd0:    begin sel_mag = mag_v[0]; sel_neg = acc_q[0][ACC_W-1]; end
      2'd1:    begin sel_mag = mag_v[1]; sel_neg = acc_q[1][ACC_W-1]; end
      default: begin sel_mag = mag_v[2]; sel_neg = acc_q[2][ACC_W-1]; end
    endcase
    unique case (cmd_i.mul_op)
      OP_X_P:   begin ma = MUL_W'(da_q[1]); mb = MUL_W'(db_q[2]); end
      OP_X_N:   begin ma = MUL_W'(da_q[2]); mb = MUL_W'(db_q[1]); end
      OP_Y_P:   begin ma = MUL_W'(da_q[2]); mb = MUL_W'(db_q[0]); end
      OP_Y_N:   begin ma = MUL_W'(da_q[0]); mb = MUL_W'(db_q[2]); end
      OP_Z_P:   begin ma = MUL_W'(da_q[0]); mb = MUL_W'(db_q[1]); end
      OP_Z_N:   begin ma = MUL_W'(da_q[1]); mb = MUL_W'(db_q[0]); end
      OP_SQ_HH: begin
        ma = MUL_W'(sel_mag[ACC_W-1:LO_W]);
        mb = MUL_W'(sel_mag[ACC_W-1:LO_W]);
      end
      OP_SQ_HL: begin
        ma = MUL_W'(sel_mag[ACC_W-1:LO_W]);
        mb = MUL_W'(sel_mag[LO_W-1:0]);
      end
      default: begin
        ma = MUL_W'(sel_mag[LO_W-1:0]);
        mb = MUL_W'(sel_mag[LO_W-1:0]);
      end
    endcase
    prod_sq = SQ_W'($unsigned(prod_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pvalid_q <= 1'b0;
    end else begin
      pvalid_q <= cmd_i.mul_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= ma * mb;
      ptag_q <= cmd_i.mul_op;
    end
  end

  // Accumulate the registered product in the cycle after it is formed.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      for (int k = 0; k < 3; k++) begin
        acc_q[k] <= '0;
      end
      sum_q <= '0;
    end else if (pvalid_q) begin
      unique case (ptag_q)
        OP_X_P:   acc_q[0] <= acc_q[0] + $signed(prod_q[ACC_W-1:0]);
        OP_X_N:   acc_q[0] <= acc_q[0] - $signed(prod_q[ACC_W-1:0]);
        OP_Y_P:   acc_q[1] <= acc_q[1] + $signed(prod_q[ACC_W-1:0]);
        OP_Y_N:   acc_q[1] <= acc_q[1] - $signed(prod_q[ACC_W-1:0]);
        OP_Z_P:   acc_q[2] <= acc_q[2] + $signed(prod_q[ACC_W-1:0]);
        OP_Z_N:   acc_q[2] <= acc_q[2] - $signed(prod_q[ACC_W-1:0]);
        OP_SQ_HH: sum_q <= sum_q + (prod_sq << SH_HH);
        OP_SQ_HL: sum_q <= sum_q + (prod_sq << SH_HL);
        default:  sum_q <= sum_q + prod_sq;
      endcase
    end
  end

  // ---------------- square root, two radicand bits a step ----------------
  logic [SQ_W-1:0] sq_sh_q;
  logic [RM_W-1:0] srem_q;
  logic [RT_W-1:0] root_q;
  logic [RN_W-1:0] s_next, s_trial;

  always_comb begin
    s_next  = {srem_q, sq_sh_q[SQ_W-1 -: 2]};
    s_trial = {1'b0, root_q, 2'b01};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      sq_sh_q <= sum_q;
      srem_q  <= '0;
      root_q  <= '0;
    end else if (cmd_i.sqrt_step) begin
      sq_sh_q <= sq_sh_q << 2;
      if (s_next >= s_trial) begin
        srem_q <= RM_W'(s_next - s_trial);
        root_q <= {root_q[RT_W-2:0], 1'b1};
      end else begin
        srem_q <= s_next[RM_W-1:0];
        root_q <= {root_q[RT_W-2:0], 1'b0};
      end
    end
  end

  // ---------------- restoring divider, one quotient bit a step ----------------
  logic [DV_W-1:0]          dv_q;
  logic [RT_W-1:0]          drem_q;
  logic [NORM_W-1:0]        quot_q;
  logic [RM_W-1:0]          d_next;
  logic                     d_bit;
  logic signed [NORM_W-1:0] qres_q [3];
  logic [NORM_W-1:0]        q_signed;

  always_comb begin
    d_next   = {drem_q, dv_q[DV_W-1]};
    d_bit    = (d_next >= {1'b0, root_q});
    q_signed = sel_neg ? NORM_W'(-quot_q) : quot_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dv_q   <= {sel_mag, {FRAC_SHIFT{1'b0}}};
      drem_q <= '0;
      quot_q <= '0;
    end else if (cmd_i.div_step) begin
      dv_q   <= dv_q << 1;
      quot_q <= {quot_q[NORM_W-2:0], d_bit};
      if (d_bit) begin
        drem_q <= RT_W'(d_next - {1'b0, root_q});
      end else begin
        drem_q <= d_next[RT_W-1:0];
      end
    end
    if (cmd_i.div_store) begin
      unique case (cmd_i.comp_idx)
        2'd0:    qres_q[0] <= q_signed;
        2'd1:    qres_q[1] <= q_signed;
        default: qres_q[2] <= q_signed;
      endcase
    end
  end

  // ---------------- output register ----------------
  logic                     out_valid_q;
  logic signed [NORM_W-1:0] nx_q, ny_q, nz_q;
  logic                     zl_q, fe_q;
  logic                     sum_zero;

  assign sum_zero = (sum_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      nx_q <= sum_zero ? '0 : qres_q[0];
      ny_q <= sum_zero ? '0 : qres_q[1];
      nz_q <= sum_zero ? '0 : qres_q[2];
      zl_q <= sum_zero;
      fe_q <= !has_d_q && last_col_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign nx_o          = nx_q;
  assign ny_o          = ny_q;
  assign nz_o          = nz_q;
  assign zero_length_o = zl_q;
  assign frame_end_o   = fe_q;

  assign status_o.tri_en   = {has_d_q & has_r_q, has_d_q & has_l_q,
                              has_u_q & has_r_q, has_u_q & has_l_q};
  assign status_o.r_zero   = r_zero_q;
  assign status_o.sum_zero = sum_zero;
  assign status_o.out_full = out_valid_q & ~out_ready_i;

endmodule

>>> rtl/core/grid_surface_normal_unit.sv
// Top level of the height-grid vertex normal unit.
// Instantiates gsn_ctrl and gsn_datapath; uses gsn_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Vertices enter in raster order, cols per row and rows per frame, then cols
// drain items close the frame. The normal of a vertex leaves when the vertex
// below it arrives, so the first row gives no result and the drain items give
// the last row. One item is in work at a time. An item of the first row makes
// four line store reads through the single registered read port, then the
// write. Any other item also runs the shared multiplier (up to 24 cross
// product and 9 square steps), the square root (one result bit a cycle, for
// ACC_W = min(2*COORD_BITS+4, 64) result bits) and the divider (one quotient
// bit a step, three components). A zero normal skips root and divide.
// A finished result waits in the output register while the next item is
// taken in. A write to cols or rows restarts the frame.
module grid_surface_normal_unit
  import gsn_pkg::*;
#(
  parameter int MAX_COLS   = MAX_COLS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]        cfg_data_i,
  // vertex items
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] vx_i,
  input  logic signed [COORD_BITS-1:0] vy_i,
  input  logic signed [COORD_BITS-1:0] vz_i,
  // normal items
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [NORM_W-1:0]     nx_o,
  output logic signed [NORM_W-1:0]     ny_o,
  output logic signed [NORM_W-1:0]     nz_o,
  output logic                         zero_length_o,
  output logic                         frame_end_o
);

  gsn_cmd_t    cmd;
  gsn_status_t status;

  // Sequencer: owns the item handshake and steps the datapath.
  gsn_ctrl #(
    .COORD_BITS(COORD_BITS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  // Datapath: line store, arithmetic and the output register.
  gsn_datapath #(
    .MAX_COLS  (MAX_COLS),
    .COORD_BITS(COORD_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .vx_i         (vx_i),
    .vy_i         (vy_i),
    .vz_i         (vz_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .nx_o         (nx_o),
    .ny_o         (ny_o),
    .nz_o         (nz_o),
    .zero_length_o(zero_length_o),
    .frame_end_o  (frame_end_o)
  );

  // A new result never overwrites one that has not been taken.
  `ASSERT_CLK(a_load_into_free, cmd.res_load |-> (!out_valid_o || out_ready_i), "result overwritten")
  // An accepted item closes the input until its work is done.
  `ASSERT_CLK(a_ready_drops, (in_valid_i && in_ready_o) |=> !in_ready_o, "ready held after accept")
  // One line store write per item.
  `ASSERT_NEVER(a_single_write, cmd.mem_we && $past(cmd.mem_we), "double line store write")

endmodule

>>> verif/tb_top.sv
// Self-checking bench for grid_surface_normal_unit: vertex grids in, unit normals out.
// Depends on gsn_pkg and the block's RTL; carries its own normal predictor.
`timescale 1ns / 1ps

module tb_top;
  import gsn_pkg::*;

  localparam int MAX_COLS = MAX_COLS_DEF;
  localparam int CW       = COORD_BITS_DEF;

  // Register indexes past the two real ones; the block ignores writes there.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Longest span the block may still be busy after the last normal arrived.
  localparam int SETTLE_CYCLES = 400;
  localparam int RAND_ITEMS    = 480;
  localparam int EDGE_ITEMS    = 32;

  typedef struct packed {
    logic signed [NORM_W-1:0] nx;
    logic signed [NORM_W-1:0] ny;
    logic signed [NORM_W-1:0] nz;
    logic                     zero_len;
    logic                     frame_end;
  } normal_t;

  typedef struct packed {
    longint x;
    longint y;
    longint z;
  } vtx_t;

  // One row of the directed table: a register write or a vertex, with an
  // optional hand-written normal for vertices whose result is obvious.
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic signed [CW-1:0]  z;
    bit                    typed;
    normal_t               want;
  } stim_row_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [CFG_IDX_W-1:0]         cfg_idx_i;
  logic [CFG_DATA_W-1:0]        cfg_data_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  logic signed [CW-1:0]         vx_i;
  logic signed [CW-1:0]         vy_i;
  logic signed [CW-1:0]         vz_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  logic signed [NORM_W-1:0]     nx_o;
  logic signed [NORM_W-1:0]     ny_o;
  logic signed [NORM_W-1:0]     nz_o;
  logic                         zero_length_o;
  logic                         frame_end_o;

  grid_surface_normal_unit DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .vx_i         (vx_i),
    .vy_i         (vy_i),
    .vz_i         (vz_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .nx_o         (nx_o),
    .ny_o         (ny_o),
    .nz_o         (nz_o),
    .zero_length_o(zero_length_o),
    .frame_end_o  (frame_end_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Normal predictor: its own copy of the registers, counters and line store.
  // ---------------------------------------------------------------------------
  logic [COLS_W-1:0] cols_q;
  logic [ROWS_W-1:0] rows_q;
  int unsigned       col_cnt;
  int unsigned       row_cnt;
  vtx_t              line_mem [0:2*MAX_COLS-1];
  longint            sum_x, sum_y, sum_z;

  normal_t normal_q[$];   // normals still owed by the block
  int      err_cnt;

  // Add (A-P) x (B-P) of one triangle to the running normal sum.
  function automatic void add_tri(vtx_t p, vtx_t a, vtx_t b);
    longint ax, ay, az, bx, by, bz;
    ax = a.x - p.x; ay = a.y - p.y; az = a.z - p.z;
    bx = b.x - p.x; by = b.y - p.y; bz = b.z - p.z;
    sum_x += ay * bz - az * by;
    sum_y += az * bx - ax * bz;
    sum_z += ax * by - ay * bx;
  endfunction

  // Scale one summed component to Q1.14, truncating toward zero.
  function automatic logic [NORM_W-1:0] unit_comp(longint c, logic [63:0] root);
    logic [63:0] m;
    logic [63:0] q;
    m = (c < 0) ? -c : c;
    q = (m << FRAC_SHIFT) / root;
    if (c < 0) q = -q;
    return q[NORM_W-1:0];
  endfunction

  function automatic logic [63:0] mag64(longint c);
    return (c < 0) ? -c : c;
  endfunction

  task automatic predict_normal(input vtx_t cur, output bit produced, output normal_t res);
    int unsigned ce, re, j, r, cb, ub;
    bit          has_u, has_d, has_l, has_r;
    vtx_t        ctr, lft, rgt, up;
    logic [127:0] ssq;
    logic [127:0] t2;
    logic [63:0]  root, t, m;
    int           b;
    ce = (cols_q < 2) ? 2 : ((cols_q > MAX_COLS) ? MAX_COLS : cols_q);
    re = (rows_q < 2) ? 2 : rows_q;
    j = col_cnt;
    r = row_cnt;
    if (j >= ce) j = 0;
    if (r > re) r = 0;
    produced = 1'b0;
    res = '0;
    if (r == 0) begin
      line_mem[j] = cur;
    end else begin
      cb = ((r - 1) % 2) * MAX_COLS;
      ub = (r % 2) * MAX_COLS;
      has_u = (r - 1) >= 1;
      has_d = r < re;
      has_l = j > 0;
      has_r = j + 1 < ce;
      sum_x = 0; sum_y = 0; sum_z = 0;
      ctr = line_mem[cb + j];
      up  = line_mem[ub + j];
      lft = has_l ? line_mem[cb + j - 1] : '0;
      rgt = has_r ? line_mem[cb + j + 1] : '0;
      if (has_u && has_l) add_tri(lft, up, ctr);
      if (has_u && has_r) add_tri(ctr, up, rgt);
      if (has_d && has_l) add_tri(lft, ctr, cur);
      if (has_d && has_r) add_tri(ctr, rgt, cur);
      // The row above is done with this column: reuse its slot for the new vertex.
      if (has_d) line_mem[ub + j] = cur;
      ssq = '0;
      m = mag64(sum_x); ssq += {64'd0, m} * {64'd0, m};
      m = mag64(sum_y); ssq += {64'd0, m} * {64'd0, m};
      m = mag64(sum_z); ssq += {64'd0, m} * {64'd0, m};
      if (ssq == 0) begin
        res.zero_len = 1'b1;
      end else begin
        root = '0;
        for (b = 63; b >= 0; b--) begin
          t  = root | (64'd1 << b);
          t2 = {64'd0, t} * {64'd0, t};
          if (t2 <= ssq) root = t;
        end
        res.nx = unit_comp(sum_x, root);
        res.ny = unit_comp(sum_y, root);
        res.nz = unit_comp(sum_z, root);
      end
      res.frame_end = !has_d && (j + 1 == ce);
      produced = 1'b1;
    end
    j++;
    if (j >= ce) begin
      j = 0;
      r = (r >= re) ? 0 : r + 1;
    end
    col_cnt = j;
    row_cnt = r;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin
    normal_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (normal_q.size() == 0) begin
        $display("[%0t] normal item with none pending", $time);
        err_cnt++;
      end else begin
        want = normal_q.pop_front();
        if (nx_o != want.nx) report_mismatch("nx", nx_o, want.nx);
        if (ny_o != want.ny) report_mismatch("ny", ny_o, want.ny);
        if (nz_o != want.nz) report_mismatch("nz", nz_o, want.nz);
        if (zero_length_o != want.zero_len)
          report_mismatch("zero_length", zero_length_o, want.zero_len);
        if (frame_end_o != want.frame_end)
          report_mismatch("frame_end", frame_end_o, want.frame_end);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, quiet stretches, and one long hold-off on request.
  // ---------------------------------------------------------------------------
  bit quiet;          // no idling on either side while set
  int hold_cycles;    // long receiver hold-off, counted here

  initial begin
    int w;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i = 1'b0;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end
      w = quiet ? 0 : $urandom_range(0, 19);
      if (w > 0) begin
        out_ready_i = 1'b0;
        repeat (w) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      // Hold ready until one normal item goes through.
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------
  // Drop valid, then wait for every owed normal and let the block settle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (normal_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register; the block must be idle. Writes to the real registers
  // restart the frame.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_COLS || idx == REG_ROWS) begin
      if (idx == REG_COLS) cols_q = data[COLS_W-1:0];
      else rows_q = data[ROWS_W-1:0];
      col_cnt = 0;
      row_cnt = 0;
    end
  endtask

  // Offer one vertex, hold it until accepted, then predict its normal.
  // A typed normal, when given, replaces the predicted one.
  task automatic send_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic signed [CW-1:0] z, input bit typed,
                             input normal_t want);
    int      gap;
    bit      produced;
    normal_t res;
    vtx_t    v;
    gap = quiet ? 0 : $urandom_range(0, 19);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    vx_i = x;
    vy_i = y;
    vz_i = z;
    do @(posedge clk_i); while (!in_ready_o);
    v.x = x; v.y = y; v.z = z;
    predict_normal(v, produced, res);
    if (produced) normal_q.insert(normal_q.size(), typed ? want : res);
  endtask

  function automatic logic signed [CW-1:0] rand_coord();
    return CW'($urandom);
  endfunction

  stim_row_t dir_tab[$];

  function automatic void add_row(stim_row_t row);
    dir_tab.insert(dir_tab.size(), row);
  endfunction

  initial begin
    int      ce, re, n, k, frame_no, rand_sent, step;
    bit      broken, force_cfg;
    normal_t nz_up, flat;
    logic signed [CW-1:0] d;

    err_cnt     = 0;
    quiet       = 1'b0;
    hold_cycles = 0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_COLS;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    vx_i = '0; vy_i = '0; vz_i = '0;
    cols_q  = COLS_RESET;
    rows_q  = ROWS_RESET;
    col_cnt = 0;
    row_cnt = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset geometry: the start of the first wide row, which gives no normals.
    // The frame is cut off here.
    for (k = 0; k < EDGE_ITEMS; k++)
      send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
    wait_idle();

    // Directed part on a 2x2 grid: a flat zero grid, a z=0 plane facing +z,
    // ignored register indexes, then full-scale coordinates.
    flat  = '{nx: '0, ny: '0, nz: '0, zero_len: 1'b1, frame_end: 1'b0};
    nz_up = '{nx: '0, ny: '0, nz: 16'sd16384, zero_len: 1'b0, frame_end: 1'b0};
    d = 16'sh1000;
    add_row('{1'b1, REG_COLS, 16'd2, '0, '0, '0, 1'b0, '0});
    add_row('{1'b1, REG_ROWS, 16'd2, '0, '0, '0, 1'b0, '0});
    for (k = 0; k < 6; k++) begin
      flat.frame_end = (k == 5);
      add_row('{1'b0, REG_COLS, '0, '0, '0, '0, k >= 2, flat});
    end
    for (k = 0; k < 6; k++) begin
      nz_up.frame_end = (k == 5);
      add_row('{1'b0, REG_COLS, '0, CW'((k % 2) * d), CW'((k / 2) * d), '0,
                k >= 2, nz_up});
    end
    add_row('{1'b1, REG_SPARE_A, 16'hFFFF, '0, '0, '0, 1'b0, '0});
    add_row('{1'b1, REG_SPARE_B, 16'h0000, '0, '0, '0, 1'b0, '0});
    add_row('{1'b0, REG_COLS, '0, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0, '0});
    add_row('{1'b0, REG_COLS, '0, 16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0, '0});
    add_row('{1'b0, REG_COLS, '0, 16'sh8000, 16'sh8000, 16'sh7FFF, 1'b0, '0});
    add_row('{1'b0, REG_COLS, '0, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 1'b0, '0});
    add_row('{1'b0, REG_COLS, '0, 16'sh5555, 16'shAAAA, 16'sh0001, 1'b0, '0});
    add_row('{1'b0, REG_COLS, '0, 16'shAAAA, 16'sh5555, 16'shFFFE, 1'b0, '0});

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        wait_idle();
        write_reg(dir_tab[i].idx, dir_tab[i].data);
      end else begin
        send_vertex(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].typed,
                    dir_tab[i].want);
      end
    end

    // Random part: mostly whole frames of small grids, some cut short, some
    // running straight into the next frame without a register write.
    rand_sent = 0;
    frame_no  = 0;
    force_cfg = 1'b1;
    while (rand_sent < RAND_ITEMS) begin
      if (force_cfg || $urandom_range(0, 3) != 0) begin
        wait_idle();
        write_reg(REG_COLS, CFG_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1)
                                                                    : $urandom_range(2, 6)));
        write_reg(REG_ROWS, CFG_DATA_W'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 1)
                                                                    : $urandom_range(2, 4)));
      end
      ce = (cols_q < 2) ? 2 : cols_q;
      re = (rows_q < 2) ? 2 : rows_q;
      n  = re * ce + ce;
      broken    = ($urandom_range(0, 7) == 0);
      force_cfg = broken;
      if (broken) n = $urandom_range(1, n - 1);
      quiet = ($urandom_range(0, 3) == 0);
      step  = $urandom_range(256, 8191);
      // Fill the block: stall the output long while vertices keep coming.
      if (frame_no == 3) hold_cycles = 3000;
      for (k = 0; k < n; k++) begin
        // Pause the input until every owed normal is out.
        if (frame_no == 5 && k == n / 2) begin
          @(negedge clk_i);
          in_valid_i = 1'b0;
          while (normal_q.size() != 0) @(posedge clk_i);
        end
        if ($urandom_range(0, 2) == 0 || k >= re * ce)
          send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
        else
          send_vertex(CW'((k % ce) * step + $urandom_range(0, 63)),
                      CW'((k / ce) * step),
                      CW'($urandom_range(0, 4095) - 2048), 1'b0, '0);
        rand_sent++;
      end
      frame_no++;
    end
    quiet = 1'b0;

    // Widest settings: cols beyond the limit, the tallest frame; cut short.
    wait_idle();
    write_reg(REG_COLS, 16'd2047);
    write_reg(REG_ROWS, 16'hFFFF);
    for (k = 0; k < EDGE_ITEMS; k++)
      send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (normal_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS grid_surface_normal_unit");
    end else begin
      $display("FAIL grid_surface_normal_unit");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #(64'd20_000_000);
    $display("FAIL grid_surface_normal_unit");
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/gsn_pkg.sv
rtl/core/gsn_ram.sv
rtl/core/gsn_ctrl.sv
rtl/core/gsn_datapath.sv
rtl/core/grid_surface_normal_unit.sv
verif/tb_top.sv
